[hdl/truehd_access_unit_header_parser_defines.svh]
// ----------------------------------------------------------------------------
// truehd access unit header parser assertion macros
// implication helpers on clk with rst_n as the disable condition
// ----------------------------------------------------------------------------
`ifndef TRUEHD_ACCESS_UNIT_HEADER_PARSER_DEFINES_SVH
`define TRUEHD_ACCESS_UNIT_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define THD_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// next-cycle implication
`define THD_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define THD_ASSERT_SAME(label, cond, prop)
`define THD_ASSERT_NEXT(label, cond, prop)
`endif

`endif

[hdl/thd_aup_pkg.sv]
// ----------------------------------------------------------------------------
// thd_aup_pkg
// shared types, constants and helpers of the truehd access unit header parser
// ----------------------------------------------------------------------------
package thd_aup_pkg;

    localparam int POS_W = 13;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [1:0]       status_t;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_SHORT   = 2'd1;
    localparam status_t STATUS_UNKNOWN = 2'd2;

    // header byte positions inside a unit
    localparam pos_t POS_LEN_HI = 13'd0;
    localparam pos_t POS_LEN_LO = 13'd1;
    localparam pos_t POS_SYNC0  = 13'd4;
    localparam pos_t POS_SYNC1  = 13'd5;
    localparam pos_t POS_SYNC2  = 13'd6;
    localparam pos_t POS_SYNC3  = 13'd7;
    localparam pos_t POS_FMT0   = 13'd8;
    localparam pos_t POS_FMT1   = 13'd9;
    localparam pos_t POS_FMT2   = 13'd10;
    localparam pos_t POS_FMT3   = 13'd11;
    localparam pos_t POS_PEAK0  = 13'd18;
    localparam pos_t POS_PEAK1  = 13'd19;
    localparam pos_t POS_SUBS   = 13'd20;
    localparam pos_t POS_SUBINF = 13'd21;

    localparam pos_t MIN_UNIT_LEN = 13'd8;
    localparam pos_t FBA_MIN_LEN  = 13'd22;

    // fba major sync signature
    localparam logic [7:0] SYNC_B0 = 8'hF8;
    localparam logic [7:0] SYNC_B1 = 8'h72;
    localparam logic [7:0] SYNC_B2 = 8'h6F;
    localparam logic [7:0] SYNC_B3 = 8'hBA;

    localparam logic [3:0]  RATE_CODE_NONE = 4'hF;
    localparam logic [3:0]  ATMOS_SUBS     = 4'd4;
    localparam logic [15:0] RATE_44K1      = 16'd44100;
    localparam logic [15:0] RATE_48K       = 16'd48000;
    localparam logic [12:0] SAMPLES_BASE   = 13'd40;

    // map bits worth two channels and bits worth one channel
    localparam logic [12:0] MAP_TWO_MASK = 13'b0_0110_0111_1001;
    localparam logic [12:0] MAP_ONE_MASK = 13'b1_1001_1000_0110;

    function automatic logic [4:0] chan_count(input logic [12:0] map);
        logic [3:0] twos;
        logic [3:0] ones;
        twos = 4'($countones(map & MAP_TWO_MASK));
        ones = 4'($countones(map & MAP_ONE_MASK));
        return {twos, 1'b0} + {1'b0, ones};
    endfunction

endpackage

[hdl/thd_aup_in_if.sv]
// ----------------------------------------------------------------------------
// thd_aup_in_if
// byte stream channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface thd_aup_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

[hdl/thd_aup_out_if.sv]
// ----------------------------------------------------------------------------
// thd_aup_out_if
// per-unit result channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface thd_aup_out_if;
    logic                  valid;
    logic                  ready;
    thd_aup_pkg::status_t  status;
    logic [12:0]           unit_length;
    logic [22:0]           sample_rate;
    logic [4:0]            channel_count;
    logic [12:0]           samples_per_unit;
    logic                  atmos;
    logic                  format_valid;
    logic [31:0]           format_info;
    logic [15:0]           peak_data_rate;

    modport source (
        output valid, output status, output unit_length, output sample_rate,
        output channel_count, output samples_per_unit, output atmos,
        output format_valid, output format_info, output peak_data_rate,
        input ready
    );
    modport sink (
        input valid, input status, input unit_length, input sample_rate,
        input channel_count, input samples_per_unit, input atmos,
        input format_valid, input format_info, input peak_data_rate,
        output ready
    );
endinterface

[hdl/truehd_access_unit_header_parser.sv]
// ----------------------------------------------------------------------------
// truehd_access_unit_header_parser
// result: the unit's last byte passes the input register, then the result loads into the output register
// throughput: 1 byte per cycle unless a result beat waits at a unit's closing byte, set by the byte position counter
// bytes keep entering while a result beat waits, up to the byte closing the next unit
// reset: position, handshake state and stored stream parameters clear to zero
// ----------------------------------------------------------------------------
`include "truehd_access_unit_header_parser_defines.svh"

module truehd_access_unit_header_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    thd_aup_in_if.sink            stream,
    thd_aup_out_if.source         result
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // unit tracking
    thd_aup_pkg::pos_t pos_reg;
    thd_aup_pkg::pos_t pos_next;
    thd_aup_pkg::pos_t size_reg;

    // captured header fields, only what the result needs
    logic [3:0] len_hi_reg;
    logic [3:0] sync_reg;
    logic [7:0] fmt0_reg;
    logic [7:0] fmt1_reg;
    logic [7:0] fmt2_reg;
    logic [7:0] fmt3_reg;
    logic [7:0] peak0_reg;
    logic [7:0] peak1_reg;
    logic [3:0] subs_reg;
    logic       subinf_top_reg;

    // stream parameters kept across units
    logic [22:0] stored_rate_reg;
    logic [4:0]  stored_chans_reg;
    logic [12:0] stored_samples_reg;

    // output register
    logic                 out_valid_reg;
    thd_aup_pkg::status_t out_status_reg;
    thd_aup_pkg::status_t out_status_next;
    logic [12:0]          out_len_reg;
    logic [12:0]          out_len_next;
    logic [22:0]          out_rate_reg;
    logic [22:0]          out_rate_next;
    logic [4:0]           out_chans_reg;
    logic [4:0]           out_chans_next;
    logic [12:0]          out_samples_reg;
    logic [12:0]          out_samples_next;
    logic                 out_atmos_reg;
    logic                 out_atmos_next;
    logic                 out_fmt_valid_reg;
    logic                 out_fmt_valid_next;
    logic [31:0]          out_fmt_info_reg;
    logic [31:0]          out_fmt_info_next;
    logic [15:0]          out_peak_reg;
    logic [15:0]          out_peak_next;

    // processing stage
    logic        adv;
    logic [12:0] len_now;
    logic        at_len_lo;
    logic        short_unit;
    logic        at_end;
    logic        emit;
    logic        fba;
    logic [3:0]  rate_code;
    logic        upd;
    logic [15:0] rate_base;
    logic [22:0] rate_new;
    logic [12:0] samples_new;
    logic [4:0]  chans_new;
    logic [22:0] rate_eff;
    logic [4:0]  chans_eff;
    logic [12:0] samples_eff;
    logic        subinf_top;
    logic        atmos;

    // the held byte moves on unless it closes a unit while a result beat still waits
    assign adv          = in_valid_reg && (!emit || !out_valid_reg || result.ready);
    assign stream.ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.valid && stream.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_byte_reg <= stream.data_byte;
        end
    end

    // length is 12 bits of bytes 0 and 1, times two
    assign len_now    = {len_hi_reg, in_byte_reg, 1'b0};
    assign at_len_lo  = (pos_reg == thd_aup_pkg::POS_LEN_LO);
    assign short_unit = at_len_lo && (len_now < thd_aup_pkg::MIN_UNIT_LEN);
    // past byte 1 the unit ends at its last byte
    assign at_end     = (pos_reg > thd_aup_pkg::POS_LEN_LO)
                        && (({1'b0, pos_reg} + 14'd1) >= {1'b0, size_reg});
    assign emit       = short_unit || at_end;

    assign fba       = (&sync_reg) && (size_reg >= thd_aup_pkg::FBA_MIN_LEN);
    assign rate_code = fmt0_reg[7:4];
    assign upd       = at_end && fba && (rate_code != thd_aup_pkg::RATE_CODE_NONE);

    assign rate_base   = rate_code[3] ? thd_aup_pkg::RATE_44K1 : thd_aup_pkg::RATE_48K;
    assign rate_new    = {7'd0, rate_base} << rate_code[2:0];
    assign samples_new = thd_aup_pkg::SAMPLES_BASE << rate_code[2:0];
    assign chans_new   = thd_aup_pkg::chan_count({fmt2_reg[4:0], fmt3_reg});

    // the result reports the values as updated by this unit
    assign rate_eff    = upd ? rate_new    : stored_rate_reg;
    assign chans_eff   = upd ? chans_new   : stored_chans_reg;
    assign samples_eff = upd ? samples_new : stored_samples_reg;

    // substream info may be the byte in hand on a 22-byte unit
    assign subinf_top = (pos_reg == thd_aup_pkg::POS_SUBINF) ? in_byte_reg[7]
                                                            : subinf_top_reg;
    assign atmos      = fba && (subs_reg == thd_aup_pkg::ATMOS_SUBS) && subinf_top;

    always_comb
    begin
        out_status_next    = thd_aup_pkg::STATUS_OK;
        out_len_next       = size_reg;
        out_rate_next      = 23'd0;
        out_chans_next     = 5'd0;
        out_samples_next   = 13'd0;
        out_atmos_next     = 1'b0;
        out_fmt_valid_next = 1'b0;
        out_fmt_info_next  = 32'd0;
        out_peak_next      = 16'd0;
        priority if (short_unit)
        begin
            out_status_next = thd_aup_pkg::STATUS_SHORT;
            out_len_next    = len_now;
        end
        else if (samples_eff == 13'd0)
        begin
            out_status_next = thd_aup_pkg::STATUS_UNKNOWN;
        end
        else
        begin
            out_rate_next      = rate_eff;
            out_chans_next     = chans_eff;
            out_samples_next   = samples_eff;
            out_atmos_next     = atmos;
            out_fmt_valid_next = fba;
            if (fba)
            begin
                out_fmt_info_next = {fmt0_reg, fmt1_reg, fmt2_reg, fmt3_reg};
                out_peak_next     = {peak0_reg, peak1_reg};
            end
        end
    end

    assign pos_next = emit ? thd_aup_pkg::POS_LEN_HI : pos_reg + 13'd1;

    // control state: position, length and stored parameters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg            <= '0;
            size_reg           <= '0;
            stored_rate_reg    <= '0;
            stored_chans_reg   <= '0;
            stored_samples_reg <= '0;
        end
        else if (adv)
        begin
            pos_reg <= pos_next;
            if (at_len_lo)
            begin
                size_reg <= len_now;
            end
            if (upd)
            begin
                stored_rate_reg    <= rate_new;
                stored_chans_reg   <= chans_new;
                stored_samples_reg <= samples_new;
            end
        end
    end

    // header capture, one field per byte position
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            unique case (pos_reg)
                thd_aup_pkg::POS_LEN_HI: len_hi_reg     <= in_byte_reg[3:0];
                thd_aup_pkg::POS_SYNC0:  sync_reg[0]    <= (in_byte_reg == thd_aup_pkg::SYNC_B0);
                thd_aup_pkg::POS_SYNC1:  sync_reg[1]    <= (in_byte_reg == thd_aup_pkg::SYNC_B1);
                thd_aup_pkg::POS_SYNC2:  sync_reg[2]    <= (in_byte_reg == thd_aup_pkg::SYNC_B2);
                thd_aup_pkg::POS_SYNC3:  sync_reg[3]    <= (in_byte_reg == thd_aup_pkg::SYNC_B3);
                thd_aup_pkg::POS_FMT0:   fmt0_reg       <= in_byte_reg;
                thd_aup_pkg::POS_FMT1:   fmt1_reg       <= in_byte_reg;
                thd_aup_pkg::POS_FMT2:   fmt2_reg       <= in_byte_reg;
                thd_aup_pkg::POS_FMT3:   fmt3_reg       <= in_byte_reg;
                thd_aup_pkg::POS_PEAK0:  peak0_reg      <= in_byte_reg;
                thd_aup_pkg::POS_PEAK1:  peak1_reg      <= in_byte_reg;
                thd_aup_pkg::POS_SUBS:   subs_reg       <= in_byte_reg[7:4];
                thd_aup_pkg::POS_SUBINF: subinf_top_reg <= in_byte_reg[7];
                default:                 ;
            endcase
        end
    end

    // output register, loaded when a unit closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            out_status_reg    <= out_status_next;
            out_len_reg       <= out_len_next;
            out_rate_reg      <= out_rate_next;
            out_chans_reg     <= out_chans_next;
            out_samples_reg   <= out_samples_next;
            out_atmos_reg     <= out_atmos_next;
            out_fmt_valid_reg <= out_fmt_valid_next;
            out_fmt_info_reg  <= out_fmt_info_next;
            out_peak_reg      <= out_peak_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.status           = out_status_reg;
    assign result.unit_length      = out_len_reg;
    assign result.sample_rate      = out_rate_reg;
    assign result.channel_count    = out_chans_reg;
    assign result.samples_per_unit = out_samples_reg;
    assign result.atmos            = out_atmos_reg;
    assign result.format_valid     = out_fmt_valid_reg;
    assign result.format_info      = out_fmt_info_reg;
    assign result.peak_data_rate   = out_peak_reg;

    // a short-length beat carries a length below the minimum
    `THD_ASSERT_SAME(a_short_len, out_valid_reg && (out_status_reg == thd_aup_pkg::STATUS_SHORT), out_len_reg < thd_aup_pkg::MIN_UNIT_LEN)
    // past the length bytes the position stays inside the unit
    `THD_ASSERT_SAME(a_pos_in_unit, pos_reg > thd_aup_pkg::POS_LEN_LO, pos_reg < size_reg)
    // once known the stream parameters never go back to unknown
    `THD_ASSERT_NEXT(a_params_kept, stored_samples_reg != 13'd0, stored_samples_reg != 13'd0)
    // an unknown-parameter beat reports no parameters
    `THD_ASSERT_SAME(a_unknown_zero, out_valid_reg && (out_status_reg == thd_aup_pkg::STATUS_UNKNOWN), (out_rate_reg == 23'd0) && (out_samples_reg == 13'd0))

endmodule
